@@ design/wdm_pkg.sv @@
// Shared types and constants of the wheat dry matter daily step unit.
package wdm_pkg;

   // configuration register indexes
   localparam logic [3:0] CSR_EB    = 4'd0;
   localparam logic [3:0] CSR_EIMAX = 4'd1;
   localparam logic [3:0] CSR_K     = 4'd2;
   localparam logic [3:0] CSR_LMAX  = 4'd3;
   localparam logic [3:0] CSR_A     = 4'd4;
   localparam logic [3:0] CSR_B     = 4'd5;
   localparam logic [3:0] CSR_TI    = 4'd6;
   localparam logic [3:0] CSR_TR    = 4'd7;

   localparam int CSR_IW = 4;
   localparam int CSR_DW = 24;

   // shared multiplier: signed 34 x 25
   localparam int MUL_AW = 34;
   localparam int MUL_BW = 25;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   // shared divider: 49-bit dividend, 33-bit divisor
   localparam int DIV_DW = 49;
   localparam int DIV_VW = 33;

   localparam logic [DIV_VW-1:0] LN2_Q16       = 33'd45426;
   localparam logic [21:0]       EXP_OFFSET    = 22'd1589910;  // 35 * ln2
   localparam logic [20:0]       ARG_NEG_LIM   = 21'd1572864;  // 24.0
   localparam logic [20:0]       ARG_POS_LIM   = 21'd786432;   // 12.0
   localparam logic [5:0]        EXP_SHIFT_PIV = 6'd49;

   // floor(2^39 / ln2): range reduction quotient, low by at most one
   localparam logic [23:0] RECIP_LN2 = 24'((64'd1 << 39) / 64'd45426);
   // biomass scale 819200 = 25 * 2^15; floor(2^28 / 25), low by at most eight
   localparam logic [7:0]  INC_DIV_RES = 8'd25;
   localparam logic [23:0] RECIP_25    = 24'((64'd1 << 28) / 64'd25);

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_VW-1:0] divisor;
   } wdm_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quotient;
      logic [DIV_VW-1:0] remainder;
   } wdm_div_rsp_type;

endpackage

@@ design/wdm_if.sv @@
// Valid/ready channel interfaces for daily weather items and results.
interface wdm_req_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temp_min;
   logic signed [14:0] temp_max;
   logic        [15:0] radiation;

   modport source (output valid, temp_min, temp_max, radiation, input ready);
   modport sink   (input valid, temp_min, temp_max, radiation, output ready);
endinterface

interface wdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] degree_days;
   logic [15:0] leaf_area;
   logic [23:0] dry_matter;

   modport source (output valid, degree_days, leaf_area, dry_matter, input ready);
   modport sink   (input valid, degree_days, leaf_area, dry_matter, output ready);
endinterface

@@ design/wheat_dry_matter_daily_step_unit.sv @@
// Top level: daily winter wheat dry matter step, sequenced over a shared multiplier and divider.
//
// One req item is a day of weather (min/max temperature, radiation); one rsp
// item comes back per day with the updated thermal sum, the day's leaf area
// index and the accumulated dry matter. Both channels are valid/ready.
// Configuration registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while the block is idle, which the block does not enforce; indexes above 7 are ignored.
// An item runs from its accept to rsp.valid through three exponentials, each
// series term a multiply plus a 49-bit pass of the bit-serial divider, a
// reciprocal on the same divider, and multiplies, clamps and result setup.
// Division by ln2 and by the biomass scale use reciprocal multiplies with a
// small correction.
// req.ready is high only while the sequencer is idle, one item at a time;
// it returns in the same cycle that rsp.valid rises.
// The result sits in an output register; a new item may be taken while it
// waits, but the next result is held back until rsp.ready takes the old one.
// Synchronous reset clears the sums, configuration registers and rsp.valid.
module wheat_dry_matter_daily_step_unit
   import wdm_pkg::*;
#(
   parameter int EXP_ITERATIONS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   wdm_req_if.sink           req,
   wdm_rsp_if.source         rsp,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int IW = $clog2(EXP_ITERATIONS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_GROW_MUL, ST_GROW_ARG, ST_EXP_QMUL, ST_EXP_QFIX, ST_EXP_TMUL,
      ST_EXP_TDIV, ST_EXP_TWAIT, ST_EXP_FIN, ST_EXP_RET, ST_RECIP_WAIT,
      ST_SEN_MUL, ST_SEN_ARG, ST_LAI_MUL, ST_LAI_CLAMP, ST_INT_MUL, ST_INT_ARG,
      ST_X_MUL, ST_Y_MUL, ST_INC_MUL, ST_INC_QMUL, ST_INC_QFIX, ST_INC_ADD, ST_OUT
   } state_type;

   typedef enum logic [1:0] {EXP_GROW, EXP_SEN, EXP_INT} exp_sel_type;

   // configuration
   logic [23:0] eb_ff, eimax_ff, k_ff, lmax_ff, a_ff, b_ff;
   logic [19:0] ti_ff, tr_ff;

   state_type   state_ff, state_in;
   exp_sel_type sel_ff, sel_in;
   logic [19:0] thermal_ff, thermal_in;
   logic [23:0] biomass_ff, biomass_in;
   logic [15:0] rad_ff, rad_in;
   logic [21:0] u_ff, u_in;
   logic [5:0]  q_ff, q_in;
   logic [15:0] r_ff, r_in;
   logic [30:0] term_ff, term_in;
   logic [31:0] sum_ff, sum_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic [31:0] exp_ff, exp_in;
   logic [16:0] g_ff, g_in;
   logic        gt_ff, gt_in;
   logic [15:0] lai_ff, lai_in;
   logic [16:0] f_ff, f_in;
   logic [32:0] inc_n_ff, inc_n_in;
   logic [28:0] inc_q_ff, inc_q_in;
   logic [7:0]  inc_r_ff, inc_r_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_dd_ff, rsp_dd_in;
   logic [15:0] rsp_lai_ff, rsp_lai_in;
   logic [23:0] rsp_dm_ff, rsp_dm_in;

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_PW-1:0] prod;
   wdm_div_req_type div_req;
   wdm_div_rsp_type div_rsp;

   wdm_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));
   wdm_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // datapath helpers
   logic [15:0] tsum;
   logic [14:0] tmean;
   logic [20:0] st_sum;
   logic [20:0] d_ti, d_tr;
   logic [MUL_PW-1:0] pabs;
   logic [46:0] arg_mag;
   logic        arg_neg;
   logic [20:0] arg_lim, arg_cmag;
   logic [21:0] u_arg;
   logic [5:0]  q_est;
   logic [21:0] r_est;
   logic        q_fix;
   logic [32:0] inc_rem;
   logic [3:0]  inc_add;
   logic [34:0] exp_big;
   logic [31:0] exp_fin;
   logic [30:0] bio_sum;
   logic [16:0] g_minus_s;

   assign tsum    = {req.temp_min[14], req.temp_min} + {req.temp_max[14], req.temp_max};
   assign tmean   = (!tsum[15] && (tsum != '0)) ? tsum[15:1] : '0;
   assign st_sum  = {1'b0, thermal_ff} + {6'b0, tmean};
   assign d_ti    = {1'b0, thermal_ff} - {1'b0, ti_ff};
   assign d_tr    = {1'b0, thermal_ff} - {1'b0, tr_ff};
   assign pabs    = prod[MUL_PW-1] ? (~prod + 1'b1) : prod;
   assign g_minus_s = g_ff - exp_ff[16:0];

   // range reduction: quotient estimate from u * 2^39/ln2, then one fixup
   assign q_est   = prod[44:39];
   assign r_est   = u_ff - ({16'b0, q_est} * 22'(LN2_Q16));
   assign q_fix   = (r_est >= 22'(LN2_Q16));

   // biomass scale: remainder of the reciprocal estimate, 25 * q by shifts
   assign inc_rem = inc_n_ff - ({prod[56:28], 4'b0} + {1'b0, prod[56:28], 3'b0}
                                + {4'b0, prod[56:28]});

   always_comb begin
      inc_add = '0;
      for (int j = 1; j <= 8; j++) begin
         if (inc_r_ff >= 8'(j * INC_DIV_RES))
            inc_add = inc_add + 1'b1;
      end
   end

   assign bio_sum = {7'b0, biomass_ff} + {2'b0, inc_q_ff} + {27'b0, inc_add};

   // exponent argument as sign and magnitude, clamped to [-24, 12]
   always_comb begin
      arg_neg = 1'b1;
      arg_mag = {19'b0, prod[39:12]};
      case (state_ff)
         ST_GROW_ARG: begin
            arg_neg = ~prod[MUL_PW-1];
            arg_mag = pabs[58:12];
         end
         ST_SEN_ARG: begin
            arg_neg = prod[MUL_PW-1];
            arg_mag = pabs[58:12];
         end
         default: ;
      endcase
      arg_lim  = arg_neg ? ARG_NEG_LIM : ARG_POS_LIM;
      arg_cmag = (arg_mag > {26'b0, arg_lim}) ? arg_lim : arg_mag[20:0];
      u_arg    = arg_neg ? (EXP_OFFSET - {1'b0, arg_cmag}) : (EXP_OFFSET + {1'b0, arg_cmag});
   end

   // scale the series sum by 2^n
   always_comb begin
      exp_big = {3'b0, sum_ff} << (q_ff - EXP_SHIFT_PIV);
      if (q_ff >= EXP_SHIFT_PIV) begin
         exp_fin = (|exp_big[34:32]) ? '1 : exp_big[31:0];
      end else begin
         exp_fin = sum_ff >> (EXP_SHIFT_PIV - q_ff);
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_GROW_MUL: begin
            mul_a = {10'b0, a_ff};
            mul_b = {{4{d_ti[20]}}, d_ti};
         end
         ST_EXP_QMUL: begin
            mul_a = {12'b0, u_ff};
            mul_b = {1'b0, RECIP_LN2};
         end
         ST_SEN_MUL: begin
            mul_a = {10'b0, b_ff};
            mul_b = {{4{d_tr[20]}}, d_tr};
         end
         ST_EXP_TMUL: begin
            mul_a = {3'b0, term_ff};
            mul_b = {9'b0, r_ff};
         end
         ST_LAI_MUL: begin
            mul_a = {10'b0, lmax_ff};
            mul_b = {8'b0, g_minus_s};
         end
         ST_INT_MUL: begin
            mul_a = {10'b0, k_ff};
            mul_b = {9'b0, lai_ff};
         end
         ST_X_MUL: begin
            mul_a = {10'b0, eb_ff};
            mul_b = {1'b0, eimax_ff};
         end
         ST_Y_MUL: begin
            mul_a = {2'b0, prod[47:16]};
            mul_b = {8'b0, f_ff};
         end
         ST_INC_MUL: begin
            mul_a = {1'b0, prod[48:16]};
            mul_b = {9'b0, rad_ff};
         end
         ST_INC_QMUL: begin
            mul_a = {1'b0, prod[47:15]};
            mul_b = {1'b0, RECIP_25};
         end
         default: ;
      endcase
   end

   // divider request
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         ST_EXP_TDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {19'b0, prod[45:16]};
            div_req.divisor  = DIV_VW'(iter_ff);
         end
         ST_EXP_RET: begin
            div_req.start    = (sel_ff == EXP_GROW);
            div_req.dividend = 49'h1_0000_0000;
            div_req.divisor  = 33'd65536 + {1'b0, exp_ff};
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      thermal_in   = thermal_ff;
      biomass_in   = biomass_ff;
      rad_in       = rad_ff;
      u_in         = u_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      iter_in      = iter_ff;
      exp_in       = exp_ff;
      g_in         = g_ff;
      gt_in        = gt_ff;
      lai_in       = lai_ff;
      f_in         = f_ff;
      inc_n_in     = inc_n_ff;
      inc_q_in     = inc_q_ff;
      inc_r_in     = inc_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_dd_in    = rsp_dd_ff;
      rsp_lai_in   = rsp_lai_ff;
      rsp_dm_in    = rsp_dm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               thermal_in = st_sum[20] ? '1 : st_sum[19:0];
               rad_in     = req.radiation;
               state_in   = ST_GROW_MUL;
            end
         end
         ST_GROW_MUL: state_in = ST_GROW_ARG;
         ST_GROW_ARG: begin
            sel_in   = EXP_GROW;
            u_in     = u_arg;
            state_in = ST_EXP_QMUL;
         end
         ST_EXP_QMUL: state_in = ST_EXP_QFIX;
         ST_EXP_QFIX: begin
            q_in     = q_est + {5'b0, q_fix};
            r_in     = q_fix ? 16'(r_est - 22'(LN2_Q16)) : r_est[15:0];
            term_in  = 31'h4000_0000;
            sum_in   = 32'h4000_0000;
            iter_in  = IW'(1);
            state_in = ST_EXP_TMUL;
         end
         ST_EXP_TMUL: state_in = ST_EXP_TDIV;
         ST_EXP_TDIV: state_in = ST_EXP_TWAIT;
         ST_EXP_TWAIT: begin
            if (div_rsp.done) begin
               term_in = div_rsp.quotient[30:0];
               sum_in  = sum_ff + {1'b0, div_rsp.quotient[30:0]};
               iter_in = iter_ff + 1'b1;
               state_in = (iter_ff == IW'(EXP_ITERATIONS)) ? ST_EXP_FIN : ST_EXP_TMUL;
            end
         end
         ST_EXP_FIN: begin
            exp_in   = exp_fin;
            state_in = ST_EXP_RET;
         end
         ST_EXP_RET: begin
            case (sel_ff)
               EXP_GROW: state_in = ST_RECIP_WAIT;
               EXP_SEN:  state_in = ST_LAI_MUL;
               default: begin
                  f_in     = (exp_ff >= 32'd65536) ? '0 : (17'd65536 - exp_ff[16:0]);
                  state_in = ST_X_MUL;
               end
            endcase
         end
         ST_RECIP_WAIT: begin
            if (div_rsp.done) begin
               g_in     = div_rsp.quotient[16:0];
               state_in = ST_SEN_MUL;
            end
         end
         ST_SEN_MUL: state_in = ST_SEN_ARG;
         ST_SEN_ARG: begin
            sel_in   = EXP_SEN;
            u_in     = u_arg;
            state_in = ST_EXP_QMUL;
         end
         ST_LAI_MUL: begin
            gt_in    = {15'b0, g_ff} > exp_ff;
            state_in = ST_LAI_CLAMP;
         end
         ST_LAI_CLAMP: begin
            if (!gt_ff) begin
               lai_in = '0;
            end else begin
               lai_in = (|prod[40:36]) ? '1 : prod[35:20];
            end
            state_in = ST_INT_MUL;
         end
         ST_INT_MUL: state_in = ST_INT_ARG;
         ST_INT_ARG: begin
            sel_in   = EXP_INT;
            u_in     = u_arg;
            state_in = ST_EXP_QMUL;
         end
         ST_X_MUL:   state_in = ST_Y_MUL;
         ST_Y_MUL:   state_in = ST_INC_MUL;
         ST_INC_MUL: state_in = ST_INC_QMUL;
         ST_INC_QMUL: begin
            inc_n_in = prod[47:15];
            state_in = ST_INC_QFIX;
         end
         ST_INC_QFIX: begin
            inc_q_in = prod[56:28];
            inc_r_in = inc_rem[7:0];
            state_in = ST_INC_ADD;
         end
         ST_INC_ADD: begin
            biomass_in = (|bio_sum[30:24]) ? '1 : bio_sum[23:0];
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the previous result has been taken
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dd_in    = thermal_ff;
               rsp_lai_in   = lai_ff;
               rsp_dm_in    = biomass_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= EXP_GROW;
         thermal_ff   <= '0;
         biomass_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         thermal_ff   <= thermal_in;
         biomass_ff   <= biomass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rad_ff     <= rad_in;
      u_ff       <= u_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      iter_ff    <= iter_in;
      exp_ff     <= exp_in;
      g_ff       <= g_in;
      gt_ff      <= gt_in;
      lai_ff     <= lai_in;
      f_ff       <= f_in;
      inc_n_ff   <= inc_n_in;
      inc_q_ff   <= inc_q_in;
      inc_r_ff   <= inc_r_in;
      rsp_dd_ff  <= rsp_dd_in;
      rsp_lai_ff <= rsp_lai_in;
      rsp_dm_ff  <= rsp_dm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eb_ff    <= '0;
         eimax_ff <= '0;
         k_ff     <= '0;
         lmax_ff  <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         ti_ff    <= '0;
         tr_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EB:    eb_ff    <= csr_wdata;
            CSR_EIMAX: eimax_ff <= csr_wdata;
            CSR_K:     k_ff     <= csr_wdata;
            CSR_LMAX:  lmax_ff  <= csr_wdata;
            CSR_A:     a_ff     <= csr_wdata;
            CSR_B:     b_ff     <= csr_wdata;
            CSR_TI:    ti_ff    <= csr_wdata[19:0];
            CSR_TR:    tr_ff    <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.degree_days = rsp_dd_ff;
   assign rsp.leaf_area   = rsp_lai_ff;
   assign rsp.dry_matter  = rsp_dm_ff;

endmodule

@@ design/wdm_mul.sv @@
// Shared signed multiplier with a registered product.
module wdm_mul
   import wdm_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_AW-1:0] op_a,
   input  logic signed [MUL_BW-1:0] op_b,
   output logic signed [MUL_PW-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

@@ design/wdm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module wdm_div
   import wdm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  wdm_div_req_type req,
   output wdm_div_rsp_type rsp
);

   localparam int CW = $clog2(DIV_DW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DIV_DW-1:0] quo_ff;
   logic [DIV_VW-1:0] rem_ff;
   logic [DIV_VW-1:0] dvs_ff;
   logic [DIV_VW:0]   shifted;
   logic [DIV_VW:0]   diff;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[DIV_DW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = ~diff[DIV_VW];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIV_DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_DW-2:0], ge};
         rem_ff <= ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ design/wdm_checker.sv @@
// Port-level checks of the daily step unit, bound to the top level.
module wdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_degree_days,
   input logic [15:0] rsp_leaf_area,
   input logic [23:0] rsp_dry_matter
);

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // a new result is only launched from the busy sequencer
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_degree_days)
         && $stable(rsp_leaf_area) && $stable(rsp_dry_matter))
      else $error("stalled result changed");

endmodule

bind wheat_dry_matter_daily_step_unit wdm_checker u_wdm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_degree_days (rsp.degree_days),
   .rsp_leaf_area   (rsp.leaf_area),
   .rsp_dry_matter  (rsp.dry_matter)
);
